// File: hw/rtl/rpcgi_pkg.sv
`timescale 1ns / 1ps
package rpcgi_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int TERM_COUNT      = 20;
  localparam int LAST_TERM       = TERM_COUNT - 1;
  localparam int IDX_W           = 7;
  localparam int WORD_W          = 48;
  localparam int DIV_STEPS       = 89;   // 49-bit magnitude followed by 40 fraction bits
  localparam int IN_DATA_W       = 200;
  localparam int OUT_DATA_W      = 104;

  // Table layout
  localparam int BASE_LINE_NUM = 0;
  localparam int BASE_LINE_DEN = TERM_COUNT;
  localparam int BASE_SAMP_NUM = 2 * TERM_COUNT;
  localparam int BASE_SAMP_DEN = 3 * TERM_COUNT;
  localparam int OFF_LINE      = 4 * TERM_COUNT;
  localparam int OFF_SAMP      = 4 * TERM_COUNT + 1;
  localparam int OFF_LAT       = 4 * TERM_COUNT + 2;
  localparam int OFF_LONG      = 4 * TERM_COUNT + 3;
  localparam int OFF_HGT       = 4 * TERM_COUNT + 4;
  localparam int SCL_LINE      = 4 * TERM_COUNT + 5;
  localparam int SCL_SAMP      = 4 * TERM_COUNT + 6;
  localparam int SCL_LAT       = 4 * TERM_COUNT + 7;
  localparam int SCL_LONG      = 4 * TERM_COUNT + 8;
  localparam int SCL_HGT       = 4 * TERM_COUNT + 9;

  localparam logic signed [47:0] MAX48   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48   = 48'sh8000_0000_0000;
  localparam logic signed [47:0] ONE_Q40 = 48'sh0100_0000_0000;

  typedef enum logic {ACT_LOAD, ACT_POINT} action_t;
  typedef enum logic [1:0] {STAT_OK, STAT_ZDIV, STAT_OVF} status_t;

  typedef struct packed {
    logic signed [47:0] val;
    logic               ovf;
  } sat_t;

  function automatic logic [47:0] mag48(input logic [47:0] x);
    return x[47] ? 48'(-x) : x;
  endfunction

  function automatic logic [48:0] mag49(input logic [48:0] x);
    return x[48] ? 49'(-x) : x;
  endfunction

  function automatic logic signed [63:0] sgn64(input logic [62:0] m, input logic neg);
    logic signed [63:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t s;
    if (v > 64'(MAX48)) begin
      s.val = MAX48;
      s.ovf = 1'b1;
    end else if (v < 64'(MIN48)) begin
      s.val = MIN48;
      s.ovf = 1'b1;
    end else begin
      s.val = v[47:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  // Factors of the product terms, indexes into the term array
  function automatic logic [4:0] term_a(input logic [4:0] j);
    logic [4:0] r;
    case (j)
      5'd4, 5'd5, 5'd7:             r = 5'd1;
      5'd6, 5'd8:                   r = 5'd2;
      5'd9:                         r = 5'd3;
      5'd10, 5'd12:                 r = 5'd4;
      5'd13:                        r = 5'd5;
      5'd16:                        r = 5'd6;
      5'd11, 5'd14, 5'd17:          r = 5'd7;
      5'd15, 5'd18:                 r = 5'd8;
      5'd19:                        r = 5'd9;
      default:                      r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] term_b(input logic [4:0] j);
    logic [4:0] r;
    case (j)
      5'd7, 5'd11:                  r = 5'd1;
      5'd4, 5'd8, 5'd12, 5'd14, 5'd15: r = 5'd2;
      default:                      r = 5'd3;
    endcase
    return r;
  endfunction

  // Evaluation order: sample num, sample den, line num, line den
  function automatic logic [6:0] poly_base(input logic [1:0] p);
    logic [6:0] r;
    case (p)
      2'd0:    r = 7'(BASE_SAMP_NUM);
      2'd1:    r = 7'(BASE_SAMP_DEN);
      2'd2:    r = 7'(BASE_LINE_NUM);
      default: r = 7'(BASE_LINE_DEN);
    endcase
    return r;
  endfunction

  // Normalization order: long, lat, height
  function automatic logic [6:0] norm_off(input logic [1:0] k);
    logic [6:0] r;
    case (k)
      2'd0:    r = 7'(OFF_LONG);
      2'd1:    r = 7'(OFF_LAT);
      default: r = 7'(OFF_HGT);
    endcase
    return r;
  endfunction

  function automatic logic [6:0] norm_scl(input logic [1:0] k);
    logic [6:0] r;
    case (k)
      2'd0:    r = 7'(SCL_LONG);
      2'd1:    r = 7'(SCL_LAT);
      default: r = 7'(SCL_HGT);
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/rpcgi_mul.sv
`timescale 1ns / 1ps
// 48x48 unsigned magnitude multiply from four 24x24 partial products
module rpcgi_mul import rpcgi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] a,
  input  logic [47:0] b,
  output logic [95:0] prod,
  output logic        done
);

  logic        busy_r;
  logic [2:0]  cnt_r;
  logic [47:0] a_r, b_r;
  logic [47:0] pp_r;
  logic [1:0]  sh_r;
  logic        pv_r;
  logic [95:0] acc_r;
  logic        done_r;
  logic [23:0] a_part, b_part;
  logic [95:0] pp_ext;

  assign a_part = cnt_r[1] ? a_r[47:24] : a_r[23:0];
  assign b_part = cnt_r[0] ? b_r[47:24] : b_r[23:0];

  always_comb begin
    case (sh_r)
      2'd0:    pp_ext = {48'b0, pp_r};
      2'd1:    pp_ext = {24'b0, pp_r, 24'b0};
      2'd2:    pp_ext = {pp_r, 48'b0};
      default: pp_ext = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pv_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        cnt_r  <= '0;
        busy_r <= 1'b1;
        pv_r   <= 1'b0;
        acc_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r != 3'd4) begin
          pp_r  <= a_part * b_part;
          sh_r  <= 2'({1'b0, cnt_r[1]} + {1'b0, cnt_r[0]});
          pv_r  <= 1'b1;
          cnt_r <= cnt_r + 3'd1;
        end else begin
          pv_r <= 1'b0;
        end
        if (pv_r) acc_r <= acc_r + pp_ext;
        if (cnt_r == 3'd4 && pv_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

// File: hw/rtl/rpcgi_div.sv
`timescale 1ns / 1ps
// Restoring divider: (num * 2^40) / den, one quotient bit per cycle, saturated to 48 bits
module rpcgi_div import rpcgi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [48:0]        num,
  input  logic [47:0]        den,
  input  logic               neg,
  input  logic               nneg,
  output logic signed [47:0] q,
  output logic               zdiv,
  output logic               ovf,
  output logic               done
);

  logic               busy_r;
  logic [6:0]         cnt_r;
  logic [88:0]        dvd_r;
  logic [47:0]        rem_r;
  logic [47:0]        den_r;
  logic [47:0]        q_r;
  logic               big_r;
  logic               neg_r;
  logic signed [47:0] q_out_r;
  logic               zdiv_r, ovf_r, done_r;
  logic [48:0]        rs;
  logic               ge;
  logic [47:0]        qn;
  logic               bign, sat;

  assign rs   = {rem_r, dvd_r[88]};
  assign ge   = rs >= {1'b0, den_r};
  assign qn   = {q_r[46:0], ge};
  assign bign = big_r | q_r[47];
  assign sat  = bign || (qn[47] && (|qn[46:0] || !neg_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        zdiv_r <= 1'b0;
        ovf_r  <= 1'b0;
        if (den == '0) begin
          zdiv_r  <= 1'b1;
          q_out_r <= nneg ? MIN48 : MAX48;
          done_r  <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          dvd_r  <= {num, 40'b0};
          den_r  <= den;
          rem_r  <= '0;
          q_r    <= '0;
          big_r  <= 1'b0;
          neg_r  <= neg;
          cnt_r  <= '0;
        end
      end else if (busy_r) begin
        rem_r <= ge ? 48'(rs - {1'b0, den_r}) : rs[47:0];
        q_r   <= qn;
        big_r <= bign;
        dvd_r <= {dvd_r[87:0], 1'b0};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (sat) begin
            ovf_r   <= 1'b1;
            q_out_r <= neg_r ? MIN48 : MAX48;
          end else begin
            q_out_r <= neg_r ? $signed(48'(-qn)) : $signed(qn);
          end
        end
      end
    end
  end

  assign q    = q_out_r;
  assign zdiv = zdiv_r;
  assign ovf  = ovf_r;
  assign done = done_r;

endmodule

// File: hw/rtl/rpc_ground_to_image_transform.sv
`timescale 1ns / 1ps
// Rational polynomial camera model, ground to image.
// Input stream: in_tuser selects the transaction kind. A load transaction writes
// one 48-bit word of the model table (80 Q8.40 coefficients, then offsets and
// scales in Q32.16) and gives no result. A point transaction carries longitude,
// latitude and height in Q32.16 and gives one result transaction with image
// sample, line and a status (ok, zero divisor, overflow saturated).
// Load the whole table before the first point; unwritten words read as garbage.
// A load leaves the block idle and ready. A point holds in_tready low until its
// result is registered: one shared divider does the three normalizations and the
// two ratios, and one shared four-pass 24x24 multiplier does 16 term products, 80
// coefficient products and 2 denormalizations, all stepped by a sequencer that
// reads the table one word at a time.
// The result sits in an output register; a new point may start while it waits.
// If the receiver still stalls when the next point finishes, hold that point in
// the final state until out_tready frees the register.
// Reset (rst_n low, synchronous) clears the sequencer and drops out_tvalid; the
// table contents are kept undefined until written.
module rpc_ground_to_image_transform import rpcgi_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // word_index[6:0], word_value[54:7], longitude[102:55], latitude[150:103],
  // height[198:151], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // sample_coord[47:0], line_coord[95:48], status[97:96], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_N_OFF, S_N_SCL, S_N_DIV, S_N_WAIT,
    S_T_MUL, S_T_WAIT,
    S_P_RD, S_P_MUL, S_P_WAIT, S_P_END,
    S_R_DIV, S_R_WAIT,
    S_D_SCL, S_D_OFF, S_D_MUL, S_D_WAIT,
    S_DONE
  } state_t;

  state_t state_r;

  // Model table
  logic [47:0]   mem [TABLE_DEPTH];
  logic [47:0]   rdata_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [1:0]  k_r, p_r;
  logic [4:0]  j_r, i_r;
  logic        r_r, d_r;
  logic signed [47:0] long_r, lat_r, hgt_r;
  logic signed [47:0] off_r, scl_r;
  logic signed [47:0] term_r  [TERM_COUNT];
  logic signed [47:0] pv_r    [4];
  logic signed [47:0] ratio_r [2];
  logic signed [47:0] res_r   [2];
  logic signed [103:0] acc_r;
  logic        mneg_r;
  logic        zdiv_r, ovf_r;
  logic        out_valid_r;
  logic signed [47:0] out_samp_r, out_line_r;
  status_t     out_status_r;

  // Shared unit hookups
  logic        mul_start, mul_done, mul_neg;
  logic [47:0] mul_a, mul_b;
  logic [95:0] mul_prod;
  logic        div_start, div_done, div_neg, div_nneg, div_zdiv, div_ovf;
  logic [48:0] div_num;
  logic [47:0] div_den;
  logic signed [47:0] div_q;

  logic signed [47:0] xsel;
  logic signed [48:0] diff;
  logic [1:0]  rn_idx, rd_idx;
  logic signed [103:0] prod_s;
  logic [103:0] acc_mag;
  sat_t        term_sat, poly_sat, den_sat;

  assign in_tready = (state_r == S_IDLE);
  assign wr_en = in_tvalid && in_tready && (in_tuser == ACT_LOAD) &&
                 (32'(in_tdata[6:0]) < TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(in_tdata[6:0])] <= in_tdata[54:7];
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    case (state_r)
      S_N_OFF: rd_addr = AW'(norm_off(k_r));
      S_N_SCL: rd_addr = AW'(norm_scl(k_r));
      S_P_RD:  rd_addr = AW'(7'(poly_base(p_r) + 7'(i_r)));
      S_D_SCL: rd_addr = d_r ? AW'(SCL_LINE) : AW'(SCL_SAMP);
      S_D_OFF: rd_addr = d_r ? AW'(OFF_LINE) : AW'(OFF_SAMP);
      default: rd_addr = '0;
    endcase
  end

  // Operand selection for the shared multiplier and divider
  always_comb begin
    case (k_r)
      2'd0:    xsel = long_r;
      2'd1:    xsel = lat_r;
      default: xsel = hgt_r;
    endcase
    diff   = {xsel[47], xsel} - {off_r[47], off_r};
    rn_idx = {r_r, 1'b0};
    rd_idx = {r_r, 1'b1};

    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_neg   = 1'b0;
    case (state_r)
      S_T_MUL: begin
        mul_start = 1'b1;
        mul_a     = mag48(term_r[term_a(j_r)]);
        mul_b     = mag48(term_r[term_b(j_r)]);
        mul_neg   = term_r[term_a(j_r)][47] ^ term_r[term_b(j_r)][47];
      end
      S_P_MUL: begin
        mul_start = 1'b1;
        mul_a     = mag48(rdata_r);
        mul_b     = mag48(term_r[i_r]);
        mul_neg   = rdata_r[47] ^ term_r[i_r][47];
      end
      S_D_MUL: begin
        mul_start = 1'b1;
        mul_a     = mag48(ratio_r[d_r]);
        mul_b     = mag48(scl_r);
        mul_neg   = ratio_r[d_r][47] ^ scl_r[47];
      end
      default: ;
    endcase

    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_neg   = 1'b0;
    div_nneg  = 1'b0;
    case (state_r)
      S_N_DIV: begin
        div_start = 1'b1;
        div_num   = mag49(diff);
        div_den   = mag48(rdata_r);
        div_neg   = diff[48] ^ rdata_r[47];
        div_nneg  = diff[48];
      end
      S_R_DIV: begin
        div_start = 1'b1;
        div_num   = {1'b0, mag48(pv_r[rn_idx])};
        div_den   = mag48(pv_r[rd_idx]);
        div_neg   = pv_r[rn_idx][47] ^ pv_r[rd_idx][47];
        div_nneg  = pv_r[rn_idx][47];
      end
      default: ;
    endcase
  end

  // Result narrowing
  always_comb begin
    prod_s   = mneg_r ? -$signed({8'b0, mul_prod}) : $signed({8'b0, mul_prod});
    acc_mag  = acc_r[103] ? 104'(-acc_r) : acc_r;
    term_sat = sat64(sgn64({7'b0, mul_prod[95:40]}, mneg_r));
    poly_sat = sat64(sgn64(acc_mag[102:40], acc_r[103]));
    den_sat  = sat64(sgn64({7'b0, mul_prod[95:40]}, mneg_r) +
                     {{16{off_r[47]}}, off_r});
  end

  rpcgi_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  rpcgi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .neg   (div_neg),
    .nneg  (div_nneg),
    .q     (div_q),
    .zdiv  (div_zdiv),
    .ovf   (div_ovf),
    .done  (div_done)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r <= '0;
      j_r <= '0;
      i_r <= '0;
      p_r <= '0;
      r_r <= 1'b0;
      d_r <= 1'b0;
    end else begin
      // drop the result once taken; the final state reloads it itself
      if (out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tuser == ACT_POINT) begin
            long_r    <= in_tdata[102:55];
            lat_r     <= in_tdata[150:103];
            hgt_r     <= in_tdata[198:151];
            zdiv_r    <= 1'b0;
            ovf_r     <= 1'b0;
            term_r[0] <= ONE_Q40;
            k_r       <= '0;
            state_r   <= S_N_OFF;
          end
        end
        S_N_OFF: state_r <= S_N_SCL;
        S_N_SCL: begin
          off_r   <= rdata_r;
          state_r <= S_N_DIV;
        end
        S_N_DIV: state_r <= S_N_WAIT;
        S_N_WAIT: begin
          if (div_done) begin
            term_r[5'(k_r) + 5'd1] <= div_q;
            zdiv_r <= zdiv_r | div_zdiv;
            ovf_r  <= ovf_r | div_ovf;
            if (k_r == 2'd2) begin
              j_r     <= 5'd4;
              state_r <= S_T_MUL;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_N_OFF;
            end
          end
        end
        S_T_MUL: begin
          mneg_r  <= mul_neg;
          state_r <= S_T_WAIT;
        end
        S_T_WAIT: begin
          if (mul_done) begin
            term_r[j_r] <= term_sat.val;
            ovf_r       <= ovf_r | term_sat.ovf;
            if (j_r == 5'(LAST_TERM)) begin
              p_r     <= '0;
              i_r     <= '0;
              acc_r   <= '0;
              state_r <= S_P_RD;
            end else begin
              j_r     <= j_r + 5'd1;
              state_r <= S_T_MUL;
            end
          end
        end
        S_P_RD: state_r <= S_P_MUL;
        S_P_MUL: begin
          mneg_r  <= mul_neg;
          state_r <= S_P_WAIT;
        end
        S_P_WAIT: begin
          if (mul_done) begin
            acc_r <= acc_r + prod_s;
            if (i_r == 5'(LAST_TERM)) begin
              state_r <= S_P_END;
            end else begin
              i_r     <= i_r + 5'd1;
              state_r <= S_P_RD;
            end
          end
        end
        S_P_END: begin
          pv_r[p_r] <= poly_sat.val;
          ovf_r     <= ovf_r | poly_sat.ovf;
          i_r       <= '0;
          acc_r     <= '0;
          if (p_r == 2'd3) begin
            r_r     <= 1'b0;
            state_r <= S_R_DIV;
          end else begin
            p_r     <= p_r + 2'd1;
            state_r <= S_P_RD;
          end
        end
        S_R_DIV: state_r <= S_R_WAIT;
        S_R_WAIT: begin
          if (div_done) begin
            ratio_r[r_r] <= div_q;
            zdiv_r <= zdiv_r | div_zdiv;
            ovf_r  <= ovf_r | div_ovf;
            if (r_r) begin
              d_r     <= 1'b0;
              state_r <= S_D_SCL;
            end else begin
              r_r     <= 1'b1;
              state_r <= S_R_DIV;
            end
          end
        end
        S_D_SCL: state_r <= S_D_OFF;
        S_D_OFF: begin
          scl_r   <= rdata_r;
          state_r <= S_D_MUL;
        end
        S_D_MUL: begin
          off_r   <= rdata_r;
          mneg_r  <= mul_neg;
          state_r <= S_D_WAIT;
        end
        S_D_WAIT: begin
          if (mul_done) begin
            res_r[d_r] <= den_sat.val;
            ovf_r      <= ovf_r | den_sat.ovf;
            if (d_r) begin
              state_r <= S_DONE;
            end else begin
              d_r     <= 1'b1;
              state_r <= S_D_SCL;
            end
          end
        end
        S_DONE: begin
          // hold here until the output register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_samp_r   <= res_r[0];
            out_line_r   <= res_r[1];
            out_status_r <= zdiv_r ? STAT_ZDIV : (ovf_r ? STAT_OVF : STAT_OK);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_status_r, out_line_r, out_samp_r};

endmodule

// File: hw/rtl/rpcgi_chk.sv
`timescale 1ns / 1ps
module rpcgi_chk import rpcgi_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[97:96] == STAT_OK || out_tdata[97:96] == STAT_ZDIV ||
                    out_tdata[97:96] == STAT_OVF))
    else $error("undefined status code");

  // a point transaction occupies the block
  a_point_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == ACT_POINT) |=> !in_tready)
    else $error("ready after point transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rpc_ground_to_image_transform rpcgi_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
